FILE: hw/rtl/vrsg_pkg.sv
// Shared types, constants and the 2^x table of the VAE sampling unit.
package vrsg_pkg;

  // log2(e) in unsigned Q16.
  localparam int LOG2E_Q16 = 94548;

  // Load enables for the two internal register stages of the exp unit.
  typedef struct packed {
    logic mid;
    logic last;
  } exp_ld_t;

  // Table of 2^(k/16) in Q16 for k = 0..16.
  function automatic logic [17:0] pow2_q16(input logic [4:0] k);
    logic [17:0] r;
    case (k)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/vae_reparam_sample_grad.sv
// Top level of the VAE reparameterization sampling and gradient unit.
// The unit is a six-stage pipeline that takes one element per clock while
// the output is not stalled and gives one result per element; a result
// leaves the exp unit through stages 4 and 5 to the output register. Each
// stage has its own valid bit and loads whenever the stage after it can
// move, so a stall at the output fills bubbles behind it and the input
// keeps taking beats until all six stages hold an element.
// The longest stage path is one multiplier (the exp product, the noise
// product or the gradient product) followed by a shift and a clip. The
// latent_scale register is written through cfg_we and cfg_wdata and must
// only change while no element is in the pipeline.
module vae_reparam_sample_grad #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [15:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic signed [DATA_WIDTH-1:0] log_var,
  input  logic signed [DATA_WIDTH-1:0] mean_val,
  input  logic signed [DATA_WIDTH-1:0] noise,
  input  logic signed [DATA_WIDTH-1:0] grad_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] primary_out,
  output logic signed [DATA_WIDTH-1:0] mean_grad,
  output logic                         saturated
);

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int P    = DW + 18;
  localparam int EW   = DW + 16;
  localparam int WIDE = 2 * DW + 20;
  localparam logic signed [17:0]     LOG2E  = 18'(vrsg_pkg::LOG2E_Q16);
  localparam logic signed [EW-1:0]   ONE_F  = EW'(1) << F;
  localparam logic signed [WIDE-1:0] SAT_HI = WIDE'({(DW-1){1'b1}});
  localparam logic signed [WIDE-1:0] SAT_LO = ~SAT_HI;

  // Clip a wide value to the data range; the top bit flags a clip.
  function automatic logic [DW:0] clip(input logic signed [WIDE-1:0] v);
    logic [DW:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[DW-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  logic [15:0] latent_scale;

  // Stage valid bits and per-stage load enables.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // Stage 1 registers.
  logic                   func1;
  logic signed [DW-1:0]   mu1, eps1, g1;
  logic signed [P-1:0]    p1;
  logic signed [DW+16:0]  smu1;
  logic signed [P-1:0]    p_next;
  logic signed [DW+16:0]  smu_next;

  // Stage 2 registers.
  logic                   func2;
  logic signed [DW-1:0]   mu2, eps2, g2;
  logic signed [DW+17:0]  mgw2;
  logic signed [DW+17:0]  mgw_next;

  // Stage 3 registers (exp results live inside the exp units).
  logic                   func3;
  logic signed [DW-1:0]   mu3, eps3, g3;
  logic signed [DW+17:0]  mgw3;
  logic [DW-1:0]          sd3, e3;
  logic                   sd_ovf3, e_ovf3;
  vrsg_pkg::exp_ld_t      exp_ld;

  // Stage 4 registers.
  logic                   func4;
  logic signed [DW-1:0]   mu4, g4, prod4;
  logic signed [DW+17:0]  mgw4;
  logic signed [WIDE-1:0] t2w4;
  logic                   flag4;
  logic signed [2*DW:0]   sdeps;
  logic                   prod_sat;
  logic signed [DW-1:0]   prod_val;
  logic signed [EW-1:0]   em1;
  logic signed [EW+16:0]  t2full;
  logic signed [WIDE-1:0] t2_next;
  logic                   flag4_next;

  // Stage 5 registers.
  logic                   func5;
  logic signed [DW+17:0]  mgw5;
  logic signed [WIDE-1:0] t2w5;
  logic signed [WIDE-1:0] pw5;
  logic                   flag5;
  logic signed [2*DW-1:0] t1full;
  logic signed [WIDE-1:0] pw_next;

  // Output stage signals.
  logic signed [WIDE-1:0] pdiff;
  logic                   pflag;
  logic signed [DW-1:0]   pval;
  logic                   mflag;
  logic signed [DW-1:0]   mval;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      latent_scale <= '0;
    end else if (cfg_we) begin
      latent_scale <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    rdy6     = !out_valid || out_ready;
    rdy5     = !v5 || rdy6;
    rdy4     = !v4 || rdy5;
    rdy3     = !v3 || rdy4;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    in_ready = rdy1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) out_valid <= v5;
    end
  end

  // Stage 1: exponent product and the scale-times-mean product.
  always_comb begin
    p_next   = P'(log_var) * P'(LOG2E);
    smu_next = (DW+17)'($signed({1'b0, latent_scale})) * (DW+17)'(mean_val);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      func1 <= func;
      mu1   <= mean_val;
      eps1  <= noise;
      g1    <= grad_in;
      p1    <= p_next;
      smu1  <= smu_next;
    end
  end

  // Stage 2: mean gradient before its clip.
  assign mgw_next = (DW+18)'(g1) - (DW+18)'(smu1 >>> F);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      func2 <= func1;
      mu2   <= mu1;
      eps2  <= eps1;
      g2    <= g1;
      mgw2  <= mgw_next;
    end
  end

  // Stages 2 and 3 of the two exp units: exp(x/2) and exp(x).
  assign exp_ld = '{mid: rdy2, last: rdy3};

  vrsg_exp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .EXTRA      (1)
  ) u_exp_sd (
    .clk   (clk),
    .ld    (exp_ld),
    .prod  (p1),
    .value (sd3),
    .ovf   (sd_ovf3)
  );

  vrsg_exp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .EXTRA      (0)
  ) u_exp_var (
    .clk   (clk),
    .ld    (exp_ld),
    .prod  (p1),
    .value (e3),
    .ovf   (e_ovf3)
  );

  always_ff @(posedge clk) begin
    if (rdy3) begin
      func3 <= func2;
      mu3   <= mu2;
      eps3  <= eps2;
      g3    <= g2;
      mgw3  <= mgw2;
    end
  end

  // Stage 4: sample product and the latent-loss term.
  always_comb begin
    sdeps                = (2*DW+1)'($signed({1'b0, sd3})) * (2*DW+1)'(eps3);
    {prod_sat, prod_val} = clip(WIDE'(sdeps >>> F));
    em1                  = $signed(EW'(e3)) - ONE_F;
    t2full               = (EW+17)'($signed({1'b0, latent_scale})) * (EW+17)'(em1);
    t2_next              = WIDE'(t2full >>> F);
    flag4_next           = sd_ovf3 | prod_sat | (func3 & e_ovf3);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      func4 <= func3;
      mu4   <= mu3;
      g4    <= g3;
      mgw4  <= mgw3;
      prod4 <= prod_val;
      t2w4  <= t2_next;
      flag4 <= flag4_next;
    end
  end

  // Stage 5: gradient product in backward mode, sample sum in forward mode.
  always_comb begin
    t1full  = (2*DW)'(prod4) * (2*DW)'(g4);
    pw_next = func4 ? WIDE'(t1full >>> (F + 1)) : (WIDE'(mu4) + WIDE'(prod4));
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      func5 <= func4;
      mgw5  <= mgw4;
      t2w5  <= t2w4;
      pw5   <= pw_next;
      flag5 <= flag4;
    end
  end

  // Output stage: final subtract, clips and the saturation flag.
  always_comb begin
    pdiff          = func5 ? (pw5 - t2w5) : pw5;
    {pflag, pval}  = clip(pdiff);
    {mflag, mval}  = clip(WIDE'(mgw5));
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      primary_out <= pval;
      mean_grad   <= func5 ? mval : '0;
      saturated   <= flag5 | pflag | (func5 & mflag);
    end
  end

endmodule

FILE: hw/rtl/vrsg_exp.sv
// Two-stage table exponential: takes x*log2(e) and returns exp in the data format.
module vrsg_exp #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  parameter int EXTRA      = 0
) (
  input  logic                         clk,
  input  vrsg_pkg::exp_ld_t            ld,
  input  logic signed [DATA_WIDTH+17:0] prod,
  output logic        [DATA_WIDTH-1:0] value,
  output logic                         ovf
);

  localparam int DW  = DATA_WIDTH;
  localparam int P   = DW + 18;
  localparam int SW  = DW + 4;
  localparam int RW  = DW + 18;
  localparam int SHW = $clog2(DW + 18);
  localparam int SH  = FRAC_BITS + EXTRA;
  localparam logic signed [SW-1:0] S_OFS = SW'(FRAC_BITS - 16);
  localparam logic [RW-1:0] DMAX_R = RW'({(DW-1){1'b1}});

  logic signed [P-1:0]  y;
  logic [3:0]           idx;
  logic [17:0]          lo;
  logic [17:0]          hi;
  logic [12:0]          diff;
  logic [24:0]          ip;
  logic [17:0]          m_next;
  logic signed [SW-1:0] s_next;
  logic [17:0]          m;
  logic signed [SW-1:0] s;
  logic signed [SW-1:0] ns;
  logic                 big;
  logic                 tiny;
  logic [SHW-1:0]       sh;
  logic [RW-1:0]        mr;
  logic [RW-1:0]        shifted;
  logic                 ovf_next;
  logic [DW-1:0]        value_next;

  // Split the exponent into integer part n and a 16-bit fraction, then
  // interpolate the mantissa from the table.
  always_comb begin
    y      = prod >>> SH;
    idx    = y[15:12];
    lo     = vrsg_pkg::pow2_q16({1'b0, idx});
    hi     = vrsg_pkg::pow2_q16({1'b0, idx} + 5'd1);
    diff   = 13'(hi - lo);
    ip     = 25'(diff) * 25'(y[11:0]);
    m_next = lo + 18'(ip >> 12);
    s_next = SW'($signed(y[P-1:16])) + S_OFS;
  end

  always_ff @(posedge clk) begin
    if (ld.mid) begin
      m <= m_next;
      s <= s_next;
    end
  end

  // Scale the mantissa by 2^s and clip to the largest positive value.
  always_comb begin
    ns       = -s;
    big      = !s[SW-1] && (s >= $signed(SW'(DW)));
    tiny     = s[SW-1] && (ns >= $signed(SW'(18)));
    sh       = s[SW-1] ? ns[SHW-1:0] : s[SHW-1:0];
    mr       = RW'(m);
    shifted  = s[SW-1] ? (mr >> sh) : (mr << sh);
    if (tiny) begin
      shifted = '0;
    end
    ovf_next   = big || (shifted > DMAX_R);
    value_next = ovf_next ? DMAX_R[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.last) begin
      value <= value_next;
      ovf   <= ovf_next;
    end
  end

endmodule

FILE: hw/rtl/vrsg_chk.sv
// Port-level checker for the VAE sampling unit and its bind to the top level.
module vrsg_chk #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] primary_out,
  input logic [DATA_WIDTH-1:0] mean_grad,
  input logic                  saturated
);

  logic       in_beat;
  logic       out_beat;
  logic [3:0] pend;
  logic [3:0] pend_next;

  // Elements accepted but not yet delivered.
  always_comb begin
    in_beat   = in_valid && in_ready;
    out_beat  = out_valid && out_ready;
    pend_next = pend + 4'(in_beat) - 4'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // A held result keeps its value until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(primary_out) &&
      $stable(mean_grad) && $stable(saturated))
    else $error("result changed while stalled");

  // With the output register empty, the pipeline must be able to take a beat.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // No result without an accepted element behind it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 4'd0)
    else $error("result without a pending element");

  // The pipeline never holds more than its six stages.
  assert property (@(posedge clk) disable iff (rst)
    pend <= 4'd6)
    else $error("too many elements in flight");

endmodule

bind vae_reparam_sample_grad vrsg_chk #(.DATA_WIDTH(DATA_WIDTH)) u_vrsg_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .primary_out (primary_out),
  .mean_grad   (mean_grad),
  .saturated   (saturated)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the VAE reparameterization sampling and gradient unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam longint LOG2E = 94548;
  localparam longint DMAX = 32767;
  localparam longint DMIN = -32768;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam logic FN_FWD = 1'b0;
  localparam logic FN_BWD = 1'b1;

  typedef struct {
    logic                 fn;
    logic signed [DW-1:0] lv;
    logic signed [DW-1:0] mu;
    logic signed [DW-1:0] eps;
    logic signed [DW-1:0] g;
  } elem_t;

  typedef struct {
    logic signed [DW-1:0] primary;
    logic signed [DW-1:0] mgrad;
    logic                 clip;
  } sample_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [15:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = 1'b0;
  logic signed [DW-1:0] log_var = '0;
  logic signed [DW-1:0] mean_val = '0;
  logic signed [DW-1:0] noise = '0;
  logic signed [DW-1:0] grad_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] primary_out;
  logic signed [DW-1:0] mean_grad;
  logic                 saturated;

  // 2^(k/16) in Q16 for the fraction part of the exponent.
  longint exp2_frac_tab [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
    92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515,
    131072
  };

  elem_t       pend_q[$];
  sample_res_t sample_q[$];
  longint      scale_model = 0;
  int          err_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          gap_left = 0;
  bit          in_beat = 1'b0;
  int          quiet_cnt = 0;

  vae_reparam_sample_grad #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .log_var    (log_var),
    .mean_val   (mean_val),
    .noise      (noise),
    .grad_in    (grad_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .primary_out(primary_out),
    .mean_grad  (mean_grad),
    .saturated  (saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clip to the signed data range and note the clip.
  function automatic longint clip_data(longint v, inout bit clip);
    if (v > DMAX) begin
      clip = 1'b1;
      return DMAX;
    end
    if (v < DMIN) begin
      clip = 1'b1;
      return DMIN;
    end
    return v;
  endfunction

  // exp(x / 2^extra) through 2^(x*log2e) with table and linear interpolation.
  function automatic longint exp_fixed(longint x, int extra, inout bit clip);
    longint y, n, f, idx, lo, m, s, v;
    y = (x * LOG2E) >>> (FB + extra);
    n = y >>> 16;
    f = y - n * 65536;
    idx = f >>> 12;
    lo = exp2_frac_tab[idx[4:0]];
    m = lo + (((exp2_frac_tab[idx[4:0] + 5'd1] - lo) * (f & 4095)) >>> 12);
    s = n + FB - 16;
    if (s > 40) begin
      clip = 1'b1;
      return DMAX;
    end
    if (s >= 0) v = m <<< s;
    else if (s <= -63) v = 0;
    else v = m >>> (-s);
    if (v > DMAX) begin
      clip = 1'b1;
      return DMAX;
    end
    return v;
  endfunction

  // Expected sample or gradient pair for one element.
  function automatic sample_res_t predict_sample(elem_t e, longint scale);
    bit          clip;
    longint      sd, prod, ex, t1, t2, pri, mg;
    sample_res_t r;
    clip = 1'b0;
    mg = 0;
    sd = exp_fixed(longint'(e.lv), 1, clip);
    prod = clip_data((sd * longint'(e.eps)) >>> FB, clip);
    if (e.fn == FN_FWD) begin
      pri = clip_data(longint'(e.mu) + prod, clip);
    end else begin
      ex = exp_fixed(longint'(e.lv), 0, clip);
      t1 = (prod * longint'(e.g)) >>> (FB + 1);
      t2 = (scale * (ex - (longint'(1) <<< FB))) >>> FB;
      pri = clip_data(t1 - t2, clip);
      mg = clip_data(longint'(e.g) - ((scale * longint'(e.mu)) >>> FB), clip);
    end
    r.primary = pri[DW-1:0];
    r.mgrad = mg[DW-1:0];
    r.clip = clip;
    return r;
  endfunction

  function automatic elem_t mk_elem(logic fn, int lv, int mu, int eps, int g);
    elem_t e;
    e.fn = fn;
    e.lv = lv[DW-1:0];
    e.mu = mu[DW-1:0];
    e.eps = eps[DW-1:0];
    e.g = g[DW-1:0];
    return e;
  endfunction

  // Mostly moderate values around zero, with full-range and extreme values mixed in.
  function automatic logic [DW-1:0] rand_operand(int span);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 2 * span)) - span;
    endcase
    return v[DW-1:0];
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    e.fn = 1'($urandom_range(0, 1));
    e.lv = rand_operand(1536);
    e.mu = rand_operand(1024);
    e.eps = rand_operand(768);
    e.g = rand_operand(1024);
    return e;
  endfunction

  // Wait until every pending element has gone through and come back.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    scale_model = longint'(v);
  endtask

  task automatic queue_random(int count);
    repeat (count) pend_q.push_back(rand_elem());
  endtask

  // Stimulus: reset setting, directed corner cases, then random phases.
  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Latent scale at its reset value.
    queue_random(60);
    drain();

    // Directed corners with the largest latent scale.
    write_scale(16'hFFFF);
    pend_q.push_back(mk_elem(FN_FWD, 0, 0, 0, 0));
    pend_q.push_back(mk_elem(FN_FWD, 0, 256, 256, 0));
    pend_q.push_back(mk_elem(FN_FWD, 32767, 0, 1, 0));
    pend_q.push_back(mk_elem(FN_FWD, -32768, 32767, -32768, 0));
    pend_q.push_back(mk_elem(FN_FWD, 2048, 0, 32767, 0));
    pend_q.push_back(mk_elem(FN_FWD, 2048, 0, -32768, 0));
    pend_q.push_back(mk_elem(FN_FWD, 0, 32767, 256, 0));
    pend_q.push_back(mk_elem(FN_FWD, 0, -32768, -256, 0));
    pend_q.push_back(mk_elem(FN_FWD, -512, -100, 300, 32767));
    pend_q.push_back(mk_elem(FN_FWD, -1, -1, -1, -1));
    pend_q.push_back(mk_elem(FN_BWD, 0, 0, 0, 0));
    pend_q.push_back(mk_elem(FN_BWD, 0, 256, 256, 256));
    pend_q.push_back(mk_elem(FN_BWD, 32767, 0, 1, 256));
    pend_q.push_back(mk_elem(FN_BWD, -32768, 0, 256, 256));
    pend_q.push_back(mk_elem(FN_BWD, 0, 32767, 0, -32768));
    pend_q.push_back(mk_elem(FN_BWD, 0, -32768, 0, 32767));
    pend_q.push_back(mk_elem(FN_BWD, 2048, 0, 32767, 32767));
    pend_q.push_back(mk_elem(FN_BWD, 2048, 0, -32768, 32767));
    pend_q.push_back(mk_elem(FN_BWD, 1400, 5, 20, -30));
    pend_q.push_back(mk_elem(FN_BWD, -1, -1, -1, -1));
    pend_q.push_back(mk_elem(FN_BWD, -300, 100, -700, 512));
    pend_q.push_back(mk_elem(FN_BWD, 32767, 32767, 32767, 32767));
    drain();

    // Unit scale, with one long hold-off at the output.
    write_scale(16'h0100);
    queue_random(104);
    hold_req = 1'b1;
    drain();

    write_scale(16'h0001);
    queue_random(104);
    drain();

    write_scale(16'($urandom_range(0, 65535)));
    queue_random(104);
    drain();

    write_scale(16'h0000);
    queue_random(104);
    drain();

    // Last stretch runs back to back on both sides.
    write_scale(16'($urandom_range(0, 65535)));
    calm = 1'b1;
    queue_random(104);
    drain();

    if (sample_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Input driver: hold a beat until taken, then offer the next one or a gap.
  always @(negedge clk) begin
    elem_t e;
    if (!rst && (!in_valid || in_beat)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && hold_left == 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        e = pend_q.pop_front();
        in_valid <= 1'b1;
        func <= e.fn;
        log_var <= e.lv;
        mean_val <= e.mu;
        noise <= e.eps;
        grad_in <= e.g;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side back-pressure: random short stalls and one long hold-off.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check each result beat, then record the expectation of each input beat.
  always @(posedge clk) begin
    sample_res_t want;
    elem_t       e;
    in_beat = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result: primary=%0d mean_grad=%0d sat=%0b",
                     primary_out, mean_grad, saturated);
          err_cnt++;
        end else begin
          want = sample_q.pop_front();
          if (primary_out !== want.primary || mean_grad !== want.mgrad ||
              saturated !== want.clip) begin
            if (err_cnt < 10)
              $display("mismatch: expected primary=%0d mean_grad=%0d sat=%0b, got %0d %0d %0b",
                       want.primary, want.mgrad, want.clip,
                       primary_out, mean_grad, saturated);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_beat = 1'b1;
        e.fn = func;
        e.lv = log_var;
        e.mu = mean_val;
        e.eps = noise;
        e.g = grad_in;
        sample_q.push_back(predict_sample(e, scale_model));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

FILE: vae_reparam_sample_grad.f
hw/rtl/vrsg_pkg.sv
hw/rtl/vrsg_exp.sv
hw/rtl/vae_reparam_sample_grad.sv
hw/rtl/vrsg_chk.sv
tb/tb_top.sv
